[sv/amc_pkg.sv]
// ----------------------------------------------------------------------------
// amc_pkg: shared types, constants and helpers for the matte compositor
// Holds the register index codes, channel order codes, the configuration
// struct, the channel lookup tables and the rounded byte multiply.
// ----------------------------------------------------------------------------
package amc_pkg;

  // Configuration port widths.
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;

  // Fully opaque alpha and the rounding bias of the byte multiply.
  localparam logic [7:0]  Opaque    = 8'd255;
  localparam logic [15:0] RoundBias = 16'd128;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_PIXEL_ORDER   = 3'd0,
    CFG_PREMULTIPLIED = 3'd1,
    CFG_MATTE_RED     = 3'd2,
    CFG_MATTE_GREEN   = 3'd3,
    CFG_MATTE_BLUE    = 3'd4
  } cfg_index_t;

  // Channel orders of a pixel in memory.
  typedef enum logic [1:0] {
    ORDER_RGBA = 2'd0,
    ORDER_BGRA = 2'd1,
    ORDER_ABGR = 2'd2,
    ORDER_ARGB = 2'd3
  } pixel_order_t;

  // Colour channels; alpha comes last.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_ALPHA = 2'd3
  } chan_t;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    pixel_order_t order;
    logic         premultiplied;
    logic [7:0]   matte_red;
    logic [7:0]   matte_green;
    logic [7:0]   matte_blue;
  } cfg_t;

  // Byte offset that holds a given channel under a given order.
  function automatic logic [1:0] chan_pos(input pixel_order_t order, input chan_t ch);
    logic [1:0] pos;
    pos = 2'd0;
    unique case (order)
      ORDER_RGBA: pos = ch;
      ORDER_BGRA: begin
        unique case (ch)
          CH_RED:   pos = 2'd2;
          CH_GREEN: pos = 2'd1;
          CH_BLUE:  pos = 2'd0;
          default:  pos = 2'd3;
        endcase
      end
      ORDER_ABGR: pos = 2'd3 - ch;
      default: begin
        unique case (ch)
          CH_ALPHA: pos = 2'd0;
          default:  pos = ch + 2'd1;
        endcase
      end
    endcase
    return pos;
  endfunction

  // Channel that sits at a given byte offset under a given order.
  function automatic chan_t chan_at(input pixel_order_t order, input logic [1:0] offs);
    chan_t ch;
    ch = CH_RED;
    unique case (order)
      ORDER_RGBA: ch = chan_t'(offs);
      ORDER_BGRA: begin
        unique case (offs)
          2'd0:    ch = CH_BLUE;
          2'd1:    ch = CH_GREEN;
          2'd2:    ch = CH_RED;
          default: ch = CH_ALPHA;
        endcase
      end
      ORDER_ABGR: ch = chan_t'(2'd3 - offs);
      default: begin
        unique case (offs)
          2'd0:    ch = CH_ALPHA;
          default: ch = chan_t'(offs - 2'd1);
        endcase
      end
    endcase
    return ch;
  endfunction

  // Exactly rounded x*y/255 on bytes.
  function automatic logic [7:0] byte_mul(input logic [7:0] x, input logic [7:0] y);
    logic [15:0] t;
    logic [15:0] s;
    t = ({8'd0, x} * {8'd0, y}) + RoundBias;
    s = t + {8'd0, t[15:8]};
    return s[15:8];
  endfunction

endpackage

[sv/amc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// amc_cfg_regs: configuration register file
// Takes writes from the plain write port and presents the live settings
// as one struct. Writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module amc_cfg_regs
  import amc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed field; unused data bits are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_ORDER:   cfg_nxt.order         = pixel_order_t'(cfg_wdata[1:0]);
        CFG_PREMULTIPLIED: cfg_nxt.premultiplied = cfg_wdata[0];
        CFG_MATTE_RED:     cfg_nxt.matte_red     = cfg_wdata;
        CFG_MATTE_GREEN:   cfg_nxt.matte_green   = cfg_wdata;
        CFG_MATTE_BLUE:    cfg_nxt.matte_blue    = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // All registers come out of reset at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/amc_blend.sv]
// ----------------------------------------------------------------------------
// amc_blend: per-pixel compositing datapath
// Picks colour and alpha out of the pixel by channel order, premultiplies
// when needed, adds the matte weighted by the inverse alpha and writes the
// result back in the same order with alpha forced opaque.
// ----------------------------------------------------------------------------
module amc_blend
  import amc_pkg::*;
(
  input  cfg_t            cfg,
  input  logic [3:0][7:0] px,
  output logic [3:0][7:0] res
);

  logic [7:0]      alpha;
  logic [7:0]      inv;
  logic [2:0][7:0] matte;
  logic [2:0][7:0] col;

  assign alpha = px[chan_pos(cfg.order, CH_ALPHA)];
  assign inv   = Opaque - alpha;
  assign matte = {cfg.matte_blue, cfg.matte_green, cfg.matte_red};

  // Three colour lanes, each with two parallel byte multiplies and an add.
  always_comb begin
    logic [7:0] c;
    for (int k = 0; k < 3; k++) begin
      c = px[chan_pos(cfg.order, chan_t'(2'(k)))];
      if (!cfg.premultiplied) begin
        c = byte_mul(c, alpha);
      end
      col[2'(k)] = byte_mul(matte[2'(k)], inv) + c;
    end
  end

  // Scatter the channels back to their byte offsets; alpha becomes opaque.
  always_comb begin
    chan_t ch;
    for (int b = 0; b < 4; b++) begin
      ch = chan_at(cfg.order, 2'(b));
      if (ch == CH_ALPHA) begin
        res[2'(b)] = Opaque;
      end else begin
        res[2'(b)] = col[ch];
      end
    end
  end

endmodule

[sv/alpha_matte_composite.sv]
// ----------------------------------------------------------------------------
// alpha_matte_composite: flattens a pixel stream onto a solid matte colour
// Two-register pipeline around the compositing datapath.
// ----------------------------------------------------------------------------
// Each pixel is a 32-bit word of four bytes whose meaning is set by
// pixel_order (RGBA, BGRA, ABGR or ARGB). The block composites it over the
// configured matte colour with exactly rounded byte multiplies, premultiplying
// straight-alpha input first, and returns the same byte order with alpha set
// to 255; a colour sum above 255 from invalid premultiplied input wraps.
// One pixel is taken every clock cycle while in_tready is high. Without
// back-pressure a pixel passes from the input transfer into the input
// register, where the multiplies and add are evaluated, and then into the
// output register, from which the result is offered on the result stream.
// Under output back-pressure the input register keeps accepting while it is
// empty, so in_tready drops only once both registers hold a pixel.
// Configuration registers are to be written only while no pixel is in flight.
module alpha_matte_composite
  import amc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // byte_zero, byte_one, byte_two, byte_three
  input  logic                 in_tlast,   // image_end_in
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // out_zero, out_one, out_two, out_three
  output logic                 out_tlast   // image_end_out
);

  cfg_t            cfg;
  logic            s1_valid_r;
  logic [3:0][7:0] s1_data_r;
  logic            s1_last_r;
  logic            out_valid_r;
  logic [3:0][7:0] out_data_r;
  logic            out_last_r;
  logic [3:0][7:0] res;
  logic            s2_ready;
  logic            in_xfer;

  amc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  amc_blend u_blend (
    .cfg (cfg),
    .px  (s1_data_r),
    .res (res)
  );

  // Each stage may load when it is empty or its contents move on.
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_xfer   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_data_r <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // An accepted pixel is always held in the input register next cycle.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted pixel did not reach the input register");

  // A stalled input stage must keep its pixel.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input stage lost a pixel under stall");

  // The alpha byte of every result is opaque.
  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[chan_pos(cfg.order, CH_ALPHA)] == Opaque))
    else $error("result alpha is not opaque");

  // With nothing behind it, a taken result leaves the output empty.
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after transfer");
`endif

endmodule
